FILE: sv/mll_pkg.sv
package mll_pkg;

   // Largest number of levels laid out and largest base dimension accepted.
   localparam int MAX_LEVELS = 13;
   localparam int MAX_DIM    = 4096;

   localparam logic [3:0]  TOP_MAX   = 4'(MAX_LEVELS - 1);
   localparam logic [12:0] DIM_CLAMP = 13'(MAX_DIM);

   localparam logic [3:0]  SMALL_LEVELS    = 4'd10;
   localparam logic [13:0] DIM_ALIGN_M1    = 14'd15;
   localparam logic [54:0] LEVEL_PAD_M1    = 55'd63;
   localparam logic [54:0] HIGH_LEVEL_STEP = 55'h400;

   // Fixed-point reciprocal shift: floor(n * ceil(2^19 / d) / 2^19) equals
   // floor(n / d) exactly for every n below 2^15 and d up to 15.
   localparam int RECIP_SHIFT = 19;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QW,
      ST_QH,
      ST_QS,
      ST_STRIDE,
      ST_ROWS,
      ST_LAYD,
      ST_LSIZE,
      ST_SL1,
      ST_SLICE,
      ST_DONE
   } state_type;

   function automatic logic [19:0] recip(input logic [3:0] d);
      logic [19:0] r;
      unique case (d)
         4'd0:    r = 20'd524288;
         4'd1:    r = 20'd524288;
         4'd2:    r = 20'd262144;
         4'd3:    r = 20'd174763;
         4'd4:    r = 20'd131072;
         4'd5:    r = 20'd104858;
         4'd6:    r = 20'd87382;
         4'd7:    r = 20'd74899;
         4'd8:    r = 20'd65536;
         4'd9:    r = 20'd58255;
         4'd10:   r = 20'd52429;
         4'd11:   r = 20'd47663;
         4'd12:   r = 20'd43691;
         4'd13:   r = 20'd40330;
         4'd14:   r = 20'd37450;
         4'd15:   r = 20'd34953;
         default: r = 20'd524288;
      endcase
      return r;
   endfunction

endpackage

FILE: sv/mip_level_layout_unit.sv
// Mip chain layout unit.
// The request channel (req_*) takes one word per texture: base width,
// height, depth, layer count, last level, an align-to-16 flag and the pixel
// block geometry of the format. The response channel (rsp_*) returns one word
// per mip level, from level 0 up to the last level, which is marked by
// rsp_chain_end. Each word carries the level width, row stride, byte offset,
// slice stride, running size and a sticky 32-bit overflow flag.
// Both channels use valid/stall; a word moves on a clock edge with valid high
// and stall low. req_stall is high while a texture is being laid out.
// All multiplications go through one 32x32 multiplier, used nine times per
// level; the divides by block width and height are reciprocal multiplies.
// A level steps through the nine multiply states and then a done state;
// req_stall stays high from the accept until the last level's word is
// loaded, and a new request can be taken only once the sequencer is idle.
// The response register decouples the two sides: the next level is
// computed while the previous one waits, and a stalled response only holds
// the sequencer at its final step.
// A new request is accepted while the last level's response still waits.
// Synchronous reset returns the sequencer to idle and drops rsp_valid; no
// request is taken while reset is high.
module mip_level_layout_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [12:0] req_base_width,
   input  logic [12:0] req_base_height,
   input  logic [9:0]  req_base_depth,
   input  logic [11:0] req_layer_count,
   input  logic [3:0]  req_top_level,
   input  logic        req_align_dims,
   input  logic [3:0]  req_block_w,
   input  logic [3:0]  req_block_h,
   input  logic [4:0]  req_block_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_level_index,
   output logic [12:0] rsp_level_width,
   output logic [16:0] rsp_row_stride,
   output logic [31:0] rsp_level_offset,
   output logic [28:0] rsp_slice_stride,
   output logic [31:0] rsp_running_size,
   output logic        rsp_size_overflow,
   output logic        rsp_chain_end
);

   mll_pkg::state_type state_ff, state_in;

   // Texture parameters, captured at accept and updated per level.
   logic [12:0] w_ff, h_ff;
   logic [9:0]  d_ff;
   logic [11:0] layers_ff;
   logic [3:0]  top_ff, level_ff;
   logic        align_ff;
   logic [3:0]  bw_ff, bh_ff;
   logic [4:0]  bb_ff;
   logic [31:0] size_ff;
   logic        ovf_ff;

   // Intermediate results of the shared multiplier.
   logic [13:0] qw_ff, qh_ff, qs_ff;
   logic [17:0] stride_ff, s1_ff;
   logic [31:0] p_ff, slice_ff;
   logic [21:0] ld_ff;
   logic [53:0] lsize_ff;

   // Response register.
   logic        rsp_valid_ff;
   logic [3:0]  out_level_ff;
   logic [12:0] out_width_ff;
   logic [16:0] out_stride_ff;
   logic [31:0] out_offset_ff, out_size_ff;
   logic [28:0] out_slice_ff;
   logic        out_ovf_ff, out_last_ff;

   logic        accept, slot_free, load_out, is_last;
   logic [12:0] w_in, h_in;
   logic [3:0]  top_in, bw_in, bh_in;
   logic [13:0] a16w, a16h, aw, ah;
   logic [14:0] nw, nh, ns;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [54:0] addend, padded;
   logic [32:0] sum;
   logic        ovf_in;
   logic [12:0] w_half, h_half;
   logic [9:0]  d_half;

   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign is_last   = (level_ff == top_ff);

   // Input clean-up: width and height clamped to 1..MAX_DIM, zero block width
   // and height become 1, and the last level saturates to the deepest supported level.
   always_comb begin
      priority if (req_base_width == 13'd0) begin
         w_in = 13'd1;
      end else if (int'(req_base_width) > mll_pkg::MAX_DIM) begin
         w_in = mll_pkg::DIM_CLAMP;
      end else begin
         w_in = req_base_width;
      end
      priority if (req_base_height == 13'd0) begin
         h_in = 13'd1;
      end else if (int'(req_base_height) > mll_pkg::MAX_DIM) begin
         h_in = mll_pkg::DIM_CLAMP;
      end else begin
         h_in = req_base_height;
      end
      bw_in  = (req_block_w == 4'd0) ? 4'd1 : req_block_w;
      bh_in  = (req_block_h == 4'd0) ? 4'd1 : req_block_h;
      top_in = (req_top_level > mll_pkg::TOP_MAX) ? mll_pkg::TOP_MAX : req_top_level;
   end

   // Aligned dimensions of the current level and the ceiling-divide numerators.
   always_comb begin
      a16w = ({1'b0, w_ff} + mll_pkg::DIM_ALIGN_M1) & ~mll_pkg::DIM_ALIGN_M1;
      a16h = ({1'b0, h_ff} + mll_pkg::DIM_ALIGN_M1) & ~mll_pkg::DIM_ALIGN_M1;
      aw   = align_ff ? a16w : {1'b0, w_ff};
      ah   = align_ff ? a16h : {1'b0, h_ff};
      nw   = {1'b0, aw}   + {11'd0, bw_ff} - 15'd1;
      nh   = {1'b0, ah}   + {11'd0, bh_ff} - 15'd1;
      ns   = {1'b0, a16w} + {11'd0, bw_ff} - 15'd1;
   end

   // Shared multiplier: the sequencer state picks its operands.
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      unique case (state_ff)
         mll_pkg::ST_QW: begin
            mul_a = {17'd0, nw};
            mul_b = {12'd0, mll_pkg::recip(bw_ff)};
         end
         mll_pkg::ST_QH: begin
            mul_a = {17'd0, nh};
            mul_b = {12'd0, mll_pkg::recip(bh_ff)};
         end
         mll_pkg::ST_QS: begin
            mul_a = {17'd0, ns};
            mul_b = {12'd0, mll_pkg::recip(bw_ff)};
         end
         mll_pkg::ST_STRIDE: begin
            mul_a = {18'd0, qw_ff};
            mul_b = {27'd0, bb_ff};
         end
         mll_pkg::ST_ROWS: begin
            mul_a = {14'd0, stride_ff};
            mul_b = {18'd0, qh_ff};
         end
         mll_pkg::ST_LAYD: begin
            mul_a = {20'd0, layers_ff};
            mul_b = {22'd0, d_ff};
         end
         mll_pkg::ST_LSIZE: begin
            mul_a = p_ff;
            mul_b = {10'd0, ld_ff};
         end
         mll_pkg::ST_SL1: begin
            mul_a = {18'd0, qs_ff};
            mul_b = {27'd0, bb_ff};
         end
         mll_pkg::ST_SLICE: begin
            mul_a = {14'd0, s1_ff};
            mul_b = {18'd0, a16h};
         end
         mll_pkg::ST_IDLE, mll_pkg::ST_DONE: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Size step of the level: low levels are padded up to 64-byte multiples, high levels
   // other than the last advance by a fixed 1 KiB, the last adds its exact size.
   always_comb begin
      padded = ({1'b0, lsize_ff} + mll_pkg::LEVEL_PAD_M1) & ~mll_pkg::LEVEL_PAD_M1;
      priority if (level_ff < mll_pkg::SMALL_LEVELS) begin
         addend = padded;
      end else if (!is_last) begin
         addend = mll_pkg::HIGH_LEVEL_STEP;
      end else begin
         addend = {1'b0, lsize_ff};
      end
      sum    = {1'b0, size_ff} + {1'b0, addend[31:0]};
      ovf_in = ovf_ff || (|addend[54:32]) || sum[32];
      w_half = (w_ff[12:1] == 12'd0) ? 13'd1 : {1'b0, w_ff[12:1]};
      h_half = (h_ff[12:1] == 12'd0) ? 13'd1 : {1'b0, h_ff[12:1]};
      d_half = (d_ff[9:1]  == 9'd0)  ? 10'd1 : {1'b0, d_ff[9:1]};
   end

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mll_pkg::ST_IDLE:   state_in = req_valid ? mll_pkg::ST_QW : mll_pkg::ST_IDLE;
         mll_pkg::ST_QW:     state_in = mll_pkg::ST_QH;
         mll_pkg::ST_QH:     state_in = mll_pkg::ST_QS;
         mll_pkg::ST_QS:     state_in = mll_pkg::ST_STRIDE;
         mll_pkg::ST_STRIDE: state_in = mll_pkg::ST_ROWS;
         mll_pkg::ST_ROWS:   state_in = mll_pkg::ST_LAYD;
         mll_pkg::ST_LAYD:   state_in = mll_pkg::ST_LSIZE;
         mll_pkg::ST_LSIZE:  state_in = mll_pkg::ST_SL1;
         mll_pkg::ST_SL1:    state_in = mll_pkg::ST_SLICE;
         mll_pkg::ST_SLICE:  state_in = mll_pkg::ST_DONE;
         mll_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = is_last ? mll_pkg::ST_IDLE : mll_pkg::ST_QW;
            end
         end
         default:            state_in = mll_pkg::ST_IDLE;
      endcase
   end

   // Sequencer: outputs. The request side also stalls while reset is high.
   always_comb begin
      req_stall = reset || (state_ff != mll_pkg::ST_IDLE);
      load_out  = (state_ff == mll_pkg::ST_DONE) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mll_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Level parameters and running totals.
   always_ff @(posedge clock) begin
      if (accept) begin
         w_ff      <= w_in;
         h_ff      <= h_in;
         d_ff      <= req_base_depth;
         layers_ff <= req_layer_count;
         top_ff    <= top_in;
         level_ff  <= 4'd0;
         align_ff  <= req_align_dims;
         bw_ff     <= bw_in;
         bh_ff     <= bh_in;
         bb_ff     <= req_block_bytes;
         size_ff   <= 32'd0;
         ovf_ff    <= 1'b0;
      end else if (load_out) begin
         w_ff     <= w_half;
         h_ff     <= h_half;
         d_ff     <= d_half;
         level_ff <= level_ff + 4'd1;
         size_ff  <= sum[31:0];
         ovf_ff   <= ovf_in;
      end
   end

   // Multiplier results, one destination per step.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         mll_pkg::ST_QW:     qw_ff     <= mul_p[mll_pkg::RECIP_SHIFT +: 14];
         mll_pkg::ST_QH:     qh_ff     <= mul_p[mll_pkg::RECIP_SHIFT +: 14];
         mll_pkg::ST_QS:     qs_ff     <= mul_p[mll_pkg::RECIP_SHIFT +: 14];
         mll_pkg::ST_STRIDE: stride_ff <= mul_p[17:0];
         mll_pkg::ST_ROWS:   p_ff      <= mul_p[31:0];
         mll_pkg::ST_LAYD:   ld_ff     <= mul_p[21:0];
         mll_pkg::ST_LSIZE:  lsize_ff  <= mul_p[53:0];
         mll_pkg::ST_SL1:    s1_ff     <= mul_p[17:0];
         mll_pkg::ST_SLICE:  slice_ff  <= mul_p[31:0];
         mll_pkg::ST_IDLE, mll_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_level_ff  <= level_ff;
         out_width_ff  <= aw[12:0];
         out_stride_ff <= stride_ff[16:0];
         out_offset_ff <= size_ff;
         out_slice_ff  <= slice_ff[28:0];
         out_size_ff   <= sum[31:0];
         out_ovf_ff    <= ovf_in;
         out_last_ff   <= is_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_level_index   = out_level_ff;
   assign rsp_level_width   = out_width_ff;
   assign rsp_row_stride    = out_stride_ff;
   assign rsp_level_offset  = out_offset_ff;
   assign rsp_slice_stride  = out_slice_ff;
   assign rsp_running_size  = out_size_ff;
   assign rsp_size_overflow = out_ovf_ff;
   assign rsp_chain_end     = out_last_ff;

   // An accepted request always starts the level sequence.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == mll_pkg::ST_QW))
      else $error("accepted request did not start the level sequence");

   // The level counter never runs past the last level while busy.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != mll_pkg::ST_IDLE) |-> (level_ff <= top_ff))
      else $error("level counter ran past the last level");

   // Loading the last level returns to idle; any other load advances the level.
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (load_out && is_last) |=> (state_ff == mll_pkg::ST_IDLE))
      else $error("last level did not end the sequence");

   a_level_step: assert property (@(posedge clock) disable iff (reset)
      (load_out && !is_last) |=> (level_ff == $past(level_ff) + 4'd1))
      else $error("level counter did not advance");

   // A loaded response word is presented on the next cycle.
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_valid)
      else $error("loaded response word not presented");

endmodule

FILE: dv/tb_mip_level_layout_unit.sv
module tb_mip_level_layout_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // Layout rules of the mip chain, kept here apart from the design's package.
   localparam int unsigned PAD_LEVEL_LIMIT = 10;
   localparam logic [63:0] PAD_BYTES       = 64'd64;
   localparam logic [63:0] ALIGN_PIXELS    = 64'd16;
   localparam logic [63:0] TAIL_STEP       = 64'h400;
   localparam logic [63:0] SIZE_LIMIT      = 64'hFFFF_FFFF;

   // The quiet time at the end is long enough to catch a stray response word.
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_LIMIT = 10;

   // One request word: the description of a single texture.
   typedef struct packed {
      logic [12:0] base_width;
      logic [12:0] base_height;
      logic [9:0]  base_depth;
      logic [11:0] layer_count;
      logic [3:0]  top_level;
      logic        align_dims;
      logic [3:0]  block_w;
      logic [3:0]  block_h;
      logic [4:0]  block_bytes;
   } texture_type;

   // One response word: the layout of a single mip level. The field order
   // matches the response ports so that the ports can be packed directly.
   typedef struct packed {
      logic [3:0]  level_index;
      logic [12:0] level_width;
      logic [16:0] row_stride;
      logic [31:0] level_offset;
      logic [28:0] slice_stride;
      logic [31:0] running_size;
      logic        size_overflow;
      logic        chain_end;
   } level_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [12:0] req_base_width = '0;
   logic [12:0] req_base_height = '0;
   logic [9:0]  req_base_depth = '0;
   logic [11:0] req_layer_count = '0;
   logic [3:0]  req_top_level = '0;
   logic        req_align_dims = 1'b0;
   logic [3:0]  req_block_w = '0;
   logic [3:0]  req_block_h = '0;
   logic [4:0]  req_block_bytes = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_level_index;
   logic [12:0] rsp_level_width;
   logic [16:0] rsp_row_stride;
   logic [31:0] rsp_level_offset;
   logic [28:0] rsp_slice_stride;
   logic [31:0] rsp_running_size;
   logic        rsp_size_overflow;
   logic        rsp_chain_end;

   // Levels predicted for every accepted texture, oldest first.
   level_type   expected_levels[$];
   int unsigned mismatches = 0;

   // Idle rates in percent per cycle for the request and response sides.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   mip_level_layout_unit i_dut (.*);

   always #5 clock = ~clock;

   // A run that hangs fails here. The slowest correct run, every texture at
   // thirteen levels behind a mostly stalled receiver, stays well under this.
   initial begin
      #10ms;
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Layout predictor
   // ---------------------------------------------------------------------

   function automatic logic [63:0] ceil_div(input logic [63:0] n, input logic [63:0] d);
      return (n + d - 64'd1) / d;
   endfunction

   function automatic logic [63:0] up16(input logic [63:0] v);
      return ceil_div(v, ALIGN_PIXELS) * ALIGN_PIXELS;
   endfunction

   // Dimensions halve per level but never drop below one.
   function automatic logic [63:0] halve(input logic [63:0] v);
      return (v > 64'd1) ? (v >> 1) : 64'd1;
   endfunction

   // A zero base dimension counts as one and an oversized one saturates.
   function automatic logic [63:0] clamp_dim(input logic [12:0] v);
      if (v == 13'd0)
         return 64'd1;
      if (v > 13'(mll_pkg::MAX_DIM))
         return 64'(mll_pkg::MAX_DIM);
      return 64'(v);
   endfunction

   // Works out every level of one texture and queues the expected words.
   // Sizes are summed exactly in 64 bits, so the overflow flag simply
   // reflects whether the running total has passed 32 bits; it stays set
   // because the total only grows.
   function automatic void lay_out_chain(input texture_type t);
      logic [63:0] w, h, d, bw, bh, bb, aw, ah, stride, lsize, prior_total, total;
      int unsigned top, lvl;
      level_type   lv;
      w     = clamp_dim(t.base_width);
      h     = clamp_dim(t.base_height);
      d     = 64'(t.base_depth);
      bw    = (t.block_w == 4'd0) ? 64'd1 : 64'(t.block_w);
      bh    = (t.block_h == 4'd0) ? 64'd1 : 64'(t.block_h);
      bb    = 64'(t.block_bytes);
      top   = (int'(t.top_level) > mll_pkg::MAX_LEVELS - 1) ?
              mll_pkg::MAX_LEVELS - 1 : int'(t.top_level);
      total = 64'd0;
      for (lvl = 0; lvl <= top; lvl++) begin
         aw          = t.align_dims ? up16(w) : w;
         ah          = t.align_dims ? up16(h) : h;
         stride      = ceil_div(aw, bw) * bb;
         lsize       = stride * ceil_div(ah, bh) * 64'(t.layer_count) * d;
         prior_total = total;
         // Small levels are padded; the tail levels advance by a fixed step,
         // except the very last one, which adds its exact size.
         if (lvl < PAD_LEVEL_LIMIT)
            total += ceil_div(lsize, PAD_BYTES) * PAD_BYTES;
         else if (lvl != top)
            total += TAIL_STEP;
         else
            total += lsize;
         lv.level_index   = 4'(lvl);
         lv.level_width   = aw[12:0];
         lv.row_stride    = stride[16:0];
         lv.level_offset  = prior_total[31:0];
         lv.slice_stride  = 29'(ceil_div(up16(w), bw) * bb * up16(h));
         lv.running_size  = total[31:0];
         lv.size_overflow = total > SIZE_LIMIT;
         lv.chain_end     = lvl == top;
         expected_levels.push_back(lv);
         w = halve(w);
         h = halve(h);
         d = halve(d);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Presents one texture and holds it until the unit takes the word. Idle
   // cycles go in front of the word only, so valid never reacts to stall and
   // a waiting word never changes.
   task automatic send_texture(input texture_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_base_width  <= t.base_width;
      req_base_height <= t.base_height;
      req_base_depth  <= t.base_depth;
      req_layer_count <= t.layer_count;
      req_top_level   <= t.top_level;
      req_align_dims  <= t.align_dims;
      req_block_w     <= t.block_w;
      req_block_h     <= t.block_h;
      req_block_bytes <= t.block_bytes;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      lay_out_chain(t);
   endtask

   function automatic texture_type tex(input int unsigned w, h, d, layers, top, align,
                                       bw, bh, bb);
      texture_type t;
      t.base_width  = 13'(w);
      t.base_height = 13'(h);
      t.base_depth  = 10'(d);
      t.layer_count = 12'(layers);
      t.top_level   = 4'(top);
      t.align_dims  = 1'(align);
      t.block_w     = 4'(bw);
      t.block_h     = 4'(bh);
      t.block_bytes = 5'(bb);
      return t;
   endfunction

   // Base dimensions lean toward powers of two, as real textures do.
   function automatic logic [12:0] pick_dim();
      case ($urandom_range(3))
         0, 1:    return 13'(1 << $urandom_range(12));
         2:       return 13'($urandom_range(64, 1));
         default: return 13'($urandom_range(4096, 1));
      endcase
   endfunction

   // Plain formats use one-pixel blocks; compressed ones mostly 4x4.
   function automatic logic [3:0] pick_block();
      case ($urandom_range(3))
         0, 1:    return 4'd1;
         2:       return 4'd4;
         default: return 4'($urandom_range(12, 1));
      endcase
   endfunction

   function automatic texture_type random_texture();
      texture_type t;
      int unsigned pick;
      // One texture in five is raw bit patterns, so that every bit of every
      // field toggles and the saturation paths get exercised.
      if ($urandom_range(9) < 2) begin
         t.base_width  = 13'($urandom);
         t.base_height = 13'($urandom);
         t.base_depth  = 10'($urandom);
         t.layer_count = 12'($urandom);
         t.top_level   = 4'($urandom);
         t.align_dims  = 1'($urandom);
         t.block_w     = 4'($urandom);
         t.block_h     = 4'($urandom);
         t.block_bytes = 5'($urandom);
         return t;
      end
      pick          = $urandom_range(99);
      t.base_width  = pick_dim();
      t.base_height = pick_dim();
      t.base_depth  = ($urandom_range(9) < 7) ? 10'd1 : 10'($urandom_range(512, 1));
      t.layer_count = (pick < 60) ? 12'd1 :
                      (pick < 85) ? 12'($urandom_range(16, 1)) :
                      12'($urandom_range(2048, 1));
      t.top_level   = 4'($urandom_range(12));
      t.align_dims  = 1'($urandom_range(1));
      t.block_w     = pick_block();
      t.block_h     = pick_block();
      t.block_bytes = ($urandom_range(1) == 0) ? 5'(1 << $urandom_range(4)) :
                      5'($urandom_range(16, 1));
      return t;
   endfunction

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   function automatic string describe(input level_type lv);
      return {$sformatf("level %0d width %0d stride %0d offset %h ",
                        lv.level_index, lv.level_width, lv.row_stride, lv.level_offset),
              $sformatf("slice %0d size %h ovf %b end %b",
                        lv.slice_stride, lv.running_size, lv.size_overflow,
                        lv.chain_end)};
   endfunction

   function automatic void note_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s", $realtime, what);
   endfunction

   // Every word taken from the response channel is compared against the
   // oldest predicted level. The stall for the next cycle is drawn after the
   // current one has been used for the acceptance decision.
   always @(posedge clock) begin : rsp_checker
      level_type got, want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_level_index, rsp_level_width, rsp_row_stride, rsp_level_offset,
                   rsp_slice_stride, rsp_running_size, rsp_size_overflow,
                   rsp_chain_end};
            if (expected_levels.size() == 0) begin
               note_mismatch({"unexpected response word: ", describe(got)});
            end else begin
               want = expected_levels.pop_front();
               if (got !== want)
                  note_mismatch({"expected ", describe(want), "\n          got      ",
                                 describe(got)});
            end
         end
         rsp_stall <= $urandom_range(99) < recv_idle_pct;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Corners of the legal ranges, the boundary at level ten, alignment on and
   // off for odd sizes, and a chain large enough to overflow 32 bits.
   task automatic test_extremes();
      send_texture(tex(1, 1, 1, 1, 0, 0, 1, 1, 1));
      send_texture(tex(4096, 4096, 512, 2048, 12, 1, 12, 12, 16));
      send_texture(tex(4096, 4096, 1, 1, 12, 0, 1, 1, 16));
      send_texture(tex(4096, 4096, 1, 2048, 12, 0, 1, 1, 16));
      send_texture(tex(4096, 1, 1, 1, 11, 0, 1, 1, 4));
      send_texture(tex(4096, 4096, 1, 1, 10, 1, 4, 4, 16));
      send_texture(tex(17, 33, 1, 3, 5, 1, 4, 4, 16));
      send_texture(tex(17, 33, 1, 3, 5, 0, 4, 4, 16));
      send_texture(tex(100, 60, 512, 1, 9, 0, 5, 4, 16));
   endtask

   // Last level beyond the chain, base sizes beyond the maximum, and every
   // field at the top of its bit width.
   task automatic test_saturation();
      send_texture(tex(64, 64, 1, 1, 13, 0, 1, 1, 4));
      send_texture(tex(64, 64, 1, 1, 15, 1, 1, 1, 4));
      send_texture(tex(8191, 4097, 1, 1, 3, 0, 1, 1, 4));
      send_texture(tex(8191, 8191, 1023, 4095, 15, 1, 15, 15, 31));
      send_texture(tex(4096, 4096, 1, 1, 0, 1, 13, 14, 31));
   endtask

   // Zero in each field that the unit treats specially.
   task automatic test_zero_fields();
      send_texture(tex(0, 0, 1, 1, 2, 0, 1, 1, 4));
      send_texture(tex(0, 8, 1, 1, 4, 1, 1, 1, 4));
      send_texture(tex(32, 32, 0, 1, 5, 0, 1, 1, 4));
      send_texture(tex(32, 32, 1, 0, 5, 0, 1, 1, 4));
      send_texture(tex(32, 32, 2, 2, 5, 1, 0, 0, 4));
      send_texture(tex(32, 32, 2, 2, 5, 0, 4, 4, 0));
      send_texture(tex(0, 0, 0, 0, 15, 0, 0, 0, 0));
   endtask

   task automatic test_random_textures(input int unsigned count);
      repeat (count)
         send_texture(random_texture());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // A slow receiver first, so that levels back up behind the response
      // register while textures arrive with short gaps.
      send_idle_pct = 15;
      recv_idle_pct = 74;
      test_extremes();
      test_saturation();
      test_zero_fields();
      test_random_textures(165);

      // Then a sparse sender against an eager receiver.
      send_idle_pct = 74;
      recv_idle_pct = 15;
      test_random_textures(165);

      // Finally back to back on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_textures(165);

      req_valid <= 1'b0;
      while (expected_levels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
